@@ rtl/mfcd_pkg.sv @@
// Shared types, constants and the control store for the median-filtered item count drive.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package mfcd_pkg;

   localparam int WINDOW_DEF = 10;

   localparam int STEP_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 14;

   localparam logic signed [12:0] THRESH_RESET = -13'sd500;
   localparam logic [13:0] LEVEL_RESET = 14'd12000;
   localparam logic [13:0] LEVEL_MAX = 14'd12000;

   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_IN      = 3'd1,
      MODE_OUT     = 3'd2,
      MODE_CNT_IN  = 3'd3,
      MODE_CNT_OUT = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_LEVEL     = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_IDLE,
      OP_STORE,
      OP_RANK,
      OP_MEDIAN,
      OP_CMD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_IS_CMD,
      COND_NOT_WRAP,
      COND_MORE_CAND,
      COND_OUT_BUSY,
      COND_NO_REQ
   } cond_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_DISPATCH = 3'd0,
      STEP_STORE    = 3'd1,
      STEP_RANK     = 3'd2,
      STEP_MEDIAN   = 3'd3,
      STEP_SPARE    = 3'd4,
      STEP_CMD      = 3'd5,
      STEP_EMIT     = 3'd6,
      STEP_IDLE     = 3'd7
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic is_cmd;
      logic wrap;
      logic more_cand;
      logic out_busy;
      logic req_valid;
   } status_type;

   // Control store: a taken condition jumps to target, otherwise fall through.
   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type w;
      unique case (step)
         STEP_DISPATCH: w = '{OP_NONE,   COND_IS_CMD,    STEP_CMD};
         STEP_STORE:    w = '{OP_STORE,  COND_NOT_WRAP,  STEP_EMIT};
         STEP_RANK:     w = '{OP_RANK,   COND_MORE_CAND, STEP_RANK};
         STEP_MEDIAN:   w = '{OP_MEDIAN, COND_ALWAYS,    STEP_EMIT};
         STEP_SPARE:    w = '{OP_NONE,   COND_ALWAYS,    STEP_IDLE};
         STEP_CMD:      w = '{OP_CMD,    COND_ALWAYS,    STEP_EMIT};
         STEP_EMIT:     w = '{OP_EMIT,   COND_OUT_BUSY,  STEP_EMIT};
         STEP_IDLE:     w = '{OP_IDLE,   COND_NO_REQ,    STEP_IDLE};
         default:       w = '{OP_NONE,   COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic is_counting(input mode_type m);
      return (m == MODE_CNT_IN) || (m == MODE_CNT_OUT);
   endfunction

endpackage

@@ rtl/mfcd_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mfcd_pkg.
module mfcd_seq
   import mfcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type step_ff, step_in;
   logic     taken;

   assign ctrl = rom_word(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:    taken = 1'b1;
         COND_IS_CMD:    taken = status.is_cmd;
         COND_NOT_WRAP:  taken = !status.wrap;
         COND_MORE_CAND: taken = status.more_cand;
         COND_OUT_BUSY:  taken = status.out_busy;
         COND_NO_REQ:    taken = !status.req_valid;
         default:        taken = 1'b1;
      endcase
      // fall through wraps from the idle step to dispatch
      step_in = taken ? ctrl.target : step_type'(step_ff + STEP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/mfcd_dpath.sv @@
// Datapath: item latch, sample window, rank-based median search and mode/count state.
// Driven by control words from mfcd_seq; depends on mfcd_pkg.
module mfcd_dpath
   import mfcd_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   input  logic               req_valid,
   input  logic               req_op,
   input  logic [2:0]         req_mode_cmd,
   input  logic [7:0]         req_target_count,
   input  logic signed [12:0] req_sample,
   input  logic signed [12:0] threshold,
   output logic               is_cmd,
   output logic               wrap,
   output logic               more_cand,
   output mode_type           mode_now,
   output logic [7:0]         remaining
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);

   logic               op_ff;
   logic [2:0]         mode_cmd_ff;
   logic [7:0]         target_ff;
   logic signed [12:0] sample_ff;

   logic signed [12:0] win_ff [WINDOW];
   logic [IDX_W-1:0]   phase_ff, phase_in;
   logic [IDX_W-1:0]   cand_ff, cand_in;
   logic signed [12:0] median_ff, median_in;
   mode_type           mode_ff, mode_in;
   logic [7:0]         count_ff, count_in;
   logic               await_ff, await_in;

   logic [WINDOW-1:0]  below;
   logic [CNT_W-1:0]   rank;
   logic signed [12:0] cand_val;
   mode_type           cmd;
   logic               present;
   logic [7:0]         count_dec;

   assign is_cmd    = !op_ff;
   assign wrap      = (phase_ff == LAST_IDX);
   assign more_cand = (cand_ff != LAST_IDX);
   assign mode_now  = mode_ff;
   assign remaining = is_counting(mode_ff) ? count_ff : 8'd0;

   // rank of the candidate in a stable ascending sort of the window
   assign cand_val = win_ff[cand_ff];
   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         below[j] = (win_ff[j] < cand_val) ||
                    ((win_ff[j] == cand_val) && (IDX_W'(j) < cand_ff));
      end
      rank = CNT_W'($countones(below));
   end

   assign cmd       = (mode_cmd_ff > 3'(MODE_CNT_OUT)) ? MODE_OFF : mode_type'(mode_cmd_ff);
   assign present   = (median_ff < threshold);
   assign count_dec = (count_ff != 8'd0) ? count_ff - 8'd1 : count_ff;

   always_comb begin
      phase_in  = phase_ff;
      cand_in   = cand_ff;
      median_in = median_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      await_in  = await_ff;
      case (ctrl.op)
         OP_STORE: begin
            phase_in = wrap ? '0 : phase_ff + IDX_W'(1);
            cand_in  = '0;
         end
         OP_RANK: begin
            if (rank == MID_RANK) begin
               median_in = cand_val;
            end
            cand_in = cand_ff + IDX_W'(1);
         end
         OP_MEDIAN: begin
            if (is_counting(mode_ff)) begin
               if (await_ff) begin
                  if (!present) begin
                     await_in = 1'b0;
                     if (count_ff == 8'd0) begin
                        mode_in = MODE_OFF;
                     end
                  end
               end else if (present) begin
                  if ((mode_ff == MODE_CNT_IN) && (count_dec == 8'd0)) begin
                     mode_in  = MODE_OFF;
                     count_in = 8'd0;
                  end else begin
                     count_in = count_dec;
                     await_in = 1'b1;
                  end
               end
            end
         end
         OP_CMD: begin
            if (is_counting(mode_ff)) begin
               if (cmd != mode_ff) begin
                  mode_in  = MODE_OFF;
                  count_in = 8'd0;
                  await_in = 1'b0;
               end
            end else if (is_counting(cmd) && (target_ff == 8'd0)) begin
               mode_in  = MODE_OFF;
               count_in = 8'd0;
               await_in = 1'b0;
            end else begin
               mode_in  = cmd;
               count_in = is_counting(cmd) ? target_ff : 8'd0;
               await_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         cand_ff  <= '0;
         mode_ff  <= MODE_OFF;
         count_ff <= 8'd0;
         await_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         cand_ff  <= cand_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         await_ff <= await_in;
         if (ctrl.op == OP_STORE) begin
            win_ff[phase_ff] <= sample_ff;
         end
      end
   end

   // item latch and median hold no control state
   always_ff @(posedge clock) begin
      median_ff <= median_in;
      if ((ctrl.op == OP_IDLE) && req_valid) begin
         op_ff       <= req_op;
         mode_cmd_ff <= req_mode_cmd;
         target_ff   <= req_target_count;
         sample_ff   <= req_sample;
      end
   end

endmodule

@@ rtl/median_filtered_item_count_drive_unit.sv @@
// Top level of the median-filtered item count drive: handshakes, settings, result register.
// Instantiates mfcd_seq and mfcd_dpath; depends on mfcd_pkg.

// One item is worked on at a time, each giving exactly one result. A command
// passes through the dispatch and command steps to the emit step, a sample that
// does not close a window through dispatch, store and emit, and a sample that
// closes one through dispatch, store, the ranking loop, the median step and emit:
// the median is found by ranking one window entry per cycle against all others.
// The next item is taken on the cycle after a result is loaded, even while that
// result still waits on rsp_stall; the block only holds a second result
// until the first is taken. Settings are written through csr_write with
// csr_index 0 for the detect threshold (low 13 bits, signed) and 1 for the
// drive level (capped at 12000 mV); write them only while the block is idle.
module median_filtered_item_count_drive_unit
   import mfcd_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [2:0]            req_mode_cmd,
   input  logic [7:0]            req_target_count,
   input  logic signed [12:0]    req_sample,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [14:0]    rsp_intake_drive,
   output logic signed [14:0]    rsp_indexer_drive,
   output logic [2:0]            rsp_mode_now,
   output logic [7:0]            rsp_remaining,
   // settings
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_type           ctrl;
   status_type         status;
   logic               is_cmd, wrap, more_cand;
   mode_type           mode_now;
   logic [7:0]         remaining;

   logic signed [12:0] thresh_ff;
   logic [13:0]        level_ff;
   logic [13:0]        level;
   logic signed [14:0] drive_pos, drive_neg;
   logic signed [14:0] intake, indexer;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_busy, load;
   logic signed [14:0] intake_ff, indexer_ff;
   logic [2:0]         mode_ff;
   logic [7:0]         remaining_ff;

   // a held result blocks only the emit step, not the next item
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign load      = (ctrl.op == OP_EMIT) && !out_busy;
   // hold off the input during reset and whenever the sequencer is busy
   assign req_stall = reset || (ctrl.op != OP_IDLE);

   assign status = '{is_cmd: is_cmd, wrap: wrap, more_cand: more_cand,
                     out_busy: out_busy, req_valid: req_valid};

   mfcd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   mfcd_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_valid        (req_valid),
      .req_op           (req_op),
      .req_mode_cmd     (req_mode_cmd),
      .req_target_count (req_target_count),
      .req_sample       (req_sample),
      .threshold        (thresh_ff),
      .is_cmd           (is_cmd),
      .wrap             (wrap),
      .more_cand        (more_cand),
      .mode_now         (mode_now),
      .remaining        (remaining)
   );

   // saturate the drive magnitude, then pick its sign from the mode
   assign level     = (level_ff > LEVEL_MAX) ? LEVEL_MAX : level_ff;
   assign drive_pos = $signed({1'b0, level});
   assign drive_neg = -drive_pos;

   always_comb begin
      intake  = '0;
      indexer = '0;
      unique case (mode_now)
         MODE_IN:      intake = drive_pos;
         MODE_OUT:     intake = drive_neg;
         MODE_CNT_IN: begin
            intake  = drive_pos;
            indexer = drive_pos;
         end
         MODE_CNT_OUT: begin
            intake  = drive_neg;
            indexer = drive_neg;
         end
         default: ;
      endcase
   end

   // drop the valid once taken, raise it on a fresh load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         level_ff     <= LEVEL_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_THRESHOLD: thresh_ff <= $signed(csr_data[12:0]);
               CSR_LEVEL:     level_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // hold the result payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         intake_ff    <= intake;
         indexer_ff   <= indexer;
         mode_ff      <= mode_now;
         remaining_ff <= remaining;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_intake_drive  = intake_ff;
   assign rsp_indexer_drive = indexer_ff;
   assign rsp_mode_now      = mode_ff;
   assign rsp_remaining     = remaining_ff;

endmodule

@@ sim/median_filtered_item_count_drive_unit_tb.sv @@
// Self-checking testbench for the median-filtered item count drive unit.
// Needs mfcd_pkg and median_filtered_item_count_drive_unit; every result is checked
// against a built-in predictor or a typed table row, over a directed table, count episodes and noise.
module median_filtered_item_count_drive_unit_tb;
   import mfcd_pkg::*;

   localparam int WINDOW = WINDOW_DEF;
   localparam int FULL_MV = 12000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE = 40;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 200;
   localparam logic ITEM_CMD = 1'b0;
   localparam logic ITEM_SAMPLE = 1'b1;
   // codes past count-out carry no name in the block; both mean off
   localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
   localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

   typedef struct packed {
      logic signed [14:0] intake;
      logic signed [14:0] indexer;
      logic [2:0]         mode;
      logic [7:0]         left;
   } drive_result;

   typedef struct packed {
      logic               op;
      logic [2:0]         mode;
      logic [7:0]         target;
      logic signed [12:0] sample;
      logic               typed;
      drive_result        want;
   } plan_row;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_op;
   logic [2:0]            req_mode_cmd;
   logic [7:0]            req_target_count;
   logic signed [12:0]    req_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [14:0]    rsp_intake_drive;
   logic signed [14:0]    rsp_indexer_drive;
   logic [2:0]            rsp_mode_now;
   logic [7:0]            rsp_remaining;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state and its copy of the settings
   logic signed [12:0] win_samples [WINDOW];
   int                 win_fill;
   mode_type           cur_mode;
   logic [7:0]         items_left;
   logic               clear_wait;
   logic signed [12:0] thresh_now;
   logic [13:0]        level_now;

   drive_result pending_drive [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          idling_on;
   bit          quiet_tail;
   bit          hold_off_req;

   median_filtered_item_count_drive_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_mode_cmd      (req_mode_cmd),
      .req_target_count  (req_target_count),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_intake_drive  (rsp_intake_drive),
      .rsp_indexer_drive (rsp_indexer_drive),
      .rsp_mode_now      (rsp_mode_now),
      .rsp_remaining     (rsp_remaining),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic stop_drive();
      cur_mode = MODE_OFF;
      items_left = '0;
      clear_wait = 1'b0;
   endtask

   // Advance the predictor by one item and return the result it causes.
   task automatic predict_drive(input plan_row row, output drive_result r);
      logic signed [12:0] sorted [WINDOW];
      logic signed [12:0] x;
      logic               present;
      mode_type           m;
      int                 i;
      int                 j;
      int                 lvl;
      if (row.op == ITEM_SAMPLE) begin
         win_samples[win_fill] = row.sample;
         win_fill++;
         if (win_fill == WINDOW) begin
            win_fill = 0;
            // insertion sort, then take the upper median
            for (i = 0; i < WINDOW; i++) begin
               x = win_samples[i];
               j = i;
               while (j > 0 && sorted[j-1] > x) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = x;
            end
            present = sorted[WINDOW/2] < thresh_now;
            if (cur_mode == MODE_CNT_IN || cur_mode == MODE_CNT_OUT) begin
               if (clear_wait) begin
                  // a clearing median only re-arms; count-out ends here
                  if (!present) begin
                     clear_wait = 1'b0;
                     if (items_left == 0)
                        stop_drive();
                  end
               end else if (present) begin
                  if (items_left != 0)
                     items_left--;
                  if (cur_mode == MODE_CNT_IN && items_left == 0)
                     stop_drive();
                  else
                     clear_wait = 1'b1;
               end
            end
         end
      end else begin
         m = (row.mode > MODE_CNT_OUT) ? MODE_OFF : mode_type'(row.mode);
         if (cur_mode == MODE_CNT_IN || cur_mode == MODE_CNT_OUT) begin
            // same counting mode keeps the count, anything else drops it
            if (m != cur_mode)
               stop_drive();
         end else if ((m == MODE_CNT_IN || m == MODE_CNT_OUT) && row.target == 0) begin
            stop_drive();
         end else begin
            cur_mode = m;
            items_left = (m == MODE_CNT_IN || m == MODE_CNT_OUT) ? row.target : 8'd0;
            clear_wait = 1'b0;
         end
      end
      lvl = (level_now > FULL_MV) ? FULL_MV : int'(level_now);
      r = '0;
      r.mode = cur_mode;
      case (cur_mode)
         MODE_IN:  r.intake = 15'(lvl);
         MODE_OUT: r.intake = 15'(-lvl);
         MODE_CNT_IN: begin
            r.intake = 15'(lvl);
            r.indexer = 15'(lvl);
            r.left = items_left;
         end
         MODE_CNT_OUT: begin
            r.intake = 15'(-lvl);
            r.indexer = 15'(-lvl);
            r.left = items_left;
         end
         default: ;
      endcase
   endtask

   function automatic plan_row cmd_row(input logic [2:0] mode_code, input logic [7:0] target);
      return '{ITEM_CMD, mode_code, target, 13'($urandom), 1'b0, '0};
   endfunction

   function automatic plan_row sample_row(input logic signed [12:0] s);
      return '{ITEM_SAMPLE, 3'($urandom), 8'($urandom), s, 1'b0, '0};
   endfunction

   // Pick a level on the present or the clear side of the threshold, sometimes anywhere.
   function automatic logic signed [12:0] pick_sample(input bit present);
      int lo;
      int hi;
      if ($urandom_range(0, 6) == 0) begin
         lo = -4095;
         hi = 4095;
      end else if (present && int'(thresh_now) > -4095) begin
         lo = -4095;
         hi = int'(thresh_now) - 1;
      end else begin
         lo = int'(thresh_now);
         hi = 4095;
      end
      return 13'(lo + int'($urandom_range(hi - lo)));
   endfunction

   // Offer one item, hold it until taken, and record what it should cause.
   task automatic send_item(input plan_row row);
      drive_result r;
      if (!quiet_tail && items_sent % 40 == 0)
         idling_on = ($urandom_range(0, 3) != 0);
      items_sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= row.op;
      req_mode_cmd <= row.mode;
      req_target_count <= row.target;
      req_sample <= row.sample;
      do @(negedge clock); while (req_stall);
      predict_drive(row, r);
      pending_drive.push_back(row.typed ? row.want : r);
      @(posedge clock);
   endtask

   task automatic write_setting(input csr_type idx, input logic [13:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_THRESHOLD)
         thresh_now = value[12:0];
      else
         level_now = value;
   endtask

   // Drop valid and wait until every expected result is back, then let it settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_drive.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare at the falling edge, where valid and stall are settled for the next edge.
   always @(negedge clock) begin
      drive_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            $display("%0t: result with no item outstanding: expected none, got mode %0d",
                     $time, rsp_mode_now);
            mismatches++;
         end else begin
            want = pending_drive.pop_front();
            check_field("intake_drive", want.intake, rsp_intake_drive);
            check_field("indexer_drive", want.indexer, rsp_indexer_drive);
            check_field("mode_now", want.mode, rsp_mode_now);
            check_field("remaining", want.left, rsp_remaining);
         end
      end
   end

   initial begin
      plan_row     plan [21];
      int          thresh_plan [PHASES];
      int          level_plan [PHASES];
      int          phase;
      int          phase_start;
      int          i;
      mode_type    cnt_mode;
      logic [7:0]  goal;
      bit          scene;
      bit          held;
      bit          paused;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = ITEM_CMD;
      req_mode_cmd = MODE_OFF;
      req_target_count = '0;
      req_sample = '0;
      csr_write = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_data = '0;
      hold_off_req = 1'b0;
      idling_on = 1'b1;
      quiet_tail = 1'b0;
      held = 1'b0;
      paused = 1'b0;

      thresh_now = THRESH_RESET;
      level_now = LEVEL_RESET;
      for (i = 0; i < WINDOW; i++)
         win_samples[i] = '0;
      win_fill = 0;
      cur_mode = MODE_OFF;
      items_left = '0;
      clear_wait = 1'b0;

      // Directed table at reset settings; typed rows are read straight off the spec.
      plan = '{
         '{ITEM_CMD, MODE_IN, 8'd0, 13'sd0, 1'b1,
           '{15'(FULL_MV), 15'sd0, MODE_IN, 8'd0}},
         '{ITEM_CMD, MODE_OUT, 8'd0, 13'sd0, 1'b1,
           '{15'(-FULL_MV), 15'sd0, MODE_OUT, 8'd0}},
         '{ITEM_CMD, MODE_UNDEF_HI, 8'd9, 13'sd0, 1'b1,
           '{15'sd0, 15'sd0, MODE_OFF, 8'd0}},
         // counting with a zero target forces off
         '{ITEM_CMD, MODE_CNT_IN, 8'd0, 13'sd0, 1'b1,
           '{15'sd0, 15'sd0, MODE_OFF, 8'd0}},
         '{ITEM_CMD, MODE_CNT_IN, 8'd255, 13'sd0, 1'b1,
           '{15'(FULL_MV), 15'(FULL_MV), MODE_CNT_IN, 8'd255}},
         // same counting mode again: ignored
         '{ITEM_CMD, MODE_CNT_IN, 8'd3, 13'sd0, 1'b1,
           '{15'(FULL_MV), 15'(FULL_MV), MODE_CNT_IN, 8'd255}},
         // other mode during a count: off
         '{ITEM_CMD, MODE_OUT, 8'd0, 13'sd0, 1'b1,
           '{15'sd0, 15'sd0, MODE_OFF, 8'd0}},
         '{ITEM_CMD, MODE_CNT_OUT, 8'd1, 13'sd0, 1'b1,
           '{15'(-FULL_MV), 15'(-FULL_MV), MODE_CNT_OUT, 8'd1}},
         // half low, half high: only the upper median keeps the item from counting
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, -13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, 13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, -13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, 13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, -13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, 13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, -13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, 13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, -13'sd4095, 1'b0, '0},
         '{ITEM_SAMPLE, MODE_OFF, 8'd0, 13'sd4095, 1'b0, '0},
         '{ITEM_CMD, MODE_CNT_OUT, 8'd5, 13'sd0, 1'b1,
           '{15'(-FULL_MV), 15'(-FULL_MV), MODE_CNT_OUT, 8'd1}},
         '{ITEM_CMD, MODE_UNDEF_LO, 8'd1, 13'sd0, 1'b1,
           '{15'sd0, 15'sd0, MODE_OFF, 8'd0}},
         '{ITEM_CMD, MODE_IN, 8'd200, 13'sd0, 1'b1,
           '{15'(FULL_MV), 15'sd0, MODE_IN, 8'd0}}
      };

      // settings per phase: threshold and level extremes, a level past saturation
      thresh_plan = '{-500, -4095, 4095, 0, 0, -1500};
      level_plan = '{12000, 0, 16383, 12001, 0, 7000};
      thresh_plan[4] = int'($urandom_range(0, 8190)) - 4095;
      level_plan[4] = $urandom_range(0, 12000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k])
         send_item(plan[k]);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         write_setting(CSR_THRESHOLD, 14'(thresh_plan[phase]));
         write_setting(CSR_LEVEL, 14'(level_plan[phase]));
         // keep the last phase free of idling on both sides
         quiet_tail = (phase == PHASES - 1);
         idling_on = !quiet_tail;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (phase == 1 && !held && items_sent - phase_start >= 30) begin
               // stall results for a long stretch while items keep coming
               hold_off_req = 1'b1;
               held = 1'b1;
            end
            if (phase == 2 && !paused && items_sent - phase_start >= 50) begin
               // pause the sender until every outstanding result is back
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_drive.size() != 0);
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
               // count episode: counting command, then samples that drift
               // between present and clear with the odd stray command
               cnt_mode = $urandom_range(0, 1) ? MODE_CNT_IN : MODE_CNT_OUT;
               goal = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 4));
               send_item(cmd_row(cnt_mode, goal));
               scene = 1'b0;
               repeat ($urandom_range(30, 90)) begin
                  if ($urandom_range(0, 11) == 0)
                     scene = !scene;
                  if ($urandom_range(0, 29) == 0)
                     send_item(cmd_row($urandom_range(0, 1) ? cnt_mode
                                                            : 3'($urandom_range(0, 7)),
                                       8'($urandom)));
                  else
                     send_item(sample_row(pick_sample(scene)));
               end
            end else begin
               // noise: any command code, any sample
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 1))
                     send_item(cmd_row(3'($urandom_range(0, 7)), 8'($urandom)));
                  else
                     send_item(sample_row(13'(int'($urandom_range(0, 8190)) - 4095)));
               end
            end
         end
      end

      drain();
      if (mismatches == 0 && pending_drive.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
